>>> sv/tws_pkg.sv
// tws_pkg: shared constants and types for the text window scroll block
// no dependencies
package tws_pkg;

	localparam int PAGES          = 8;
	localparam int CELLS_PER_PAGE = 2048;
	localparam int ROWS           = 25;
	localparam int STORE_DEPTH    = PAGES * CELLS_PER_PAGE;
	localparam int ADDR_W         = $clog2(STORE_DEPTH);
	localparam int ROW_W          = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W          = 7;
	// width of the largest in-page offset that a row and column can form
	localparam int OFF_W          = $clog2((ROWS - 1) * 127 + 127 + 1);
	localparam int CELL_W         = 16;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [6:0] COLS_RESET = 7'd80;

	// operation codes
	localparam logic [2:0] OP_WRITE  = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_SCR_UP = 3'd2;
	localparam logic [2:0] OP_SCR_DN = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	// configuration register indexes
	localparam logic CFG_COLS  = 1'b0;
	localparam logic CFG_APAGE = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CELL_W-1:0] cell_t;

endpackage

>>> sv/text_window_scroll.sv
// text_window_scroll: top level, operation sequencer around the cell memory
// depends on tws_pkg and tws_ram
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | operation page row col char_code attribute
//          |           |                     | lines top left bottom right
//  out     | output    | out_valid/out_stall | read_char read_attribute done_res
//  cfg     | input     | cfg_wr_en           | cfg_index cfg_data
//
// a cell write or an undefined code goes from idle through the finish state; a cell read passes the read state first.
// scroll walks the window cell by cell: one memory port read and write a cycle.
// page clear and zero-line scroll write the whole active page, one cell written per cycle.
// after reset a clearing pass zeroes the store; in_stall is high meanwhile.
// a stalled result is held in the output register; the next beat is still taken.
module text_window_scroll (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [2:0] page,
	input  logic [4:0] row,
	input  logic [6:0] col,
	input  logic [7:0] char_code,
	input  logic [7:0] attribute,
	input  logic [7:0] lines,
	input  logic [7:0] top,
	input  logic [7:0] left,
	input  logic [7:0] bottom,
	input  logic [7:0] right,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_char,
	output logic [7:0] read_attribute,
	output logic       done_res,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);

	localparam int ROW_W = tws_pkg::ROW_W;
	localparam int OFF_W = tws_pkg::OFF_W;
	localparam int ADDR_W = tws_pkg::ADDR_W;

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_CLR  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [6:0] cols_q;
	logic [2:0] apage_q;
	logic [ADDR_W-1:0] cnt_q;

	// scroll window and sweep registers
	logic [ROW_W-1:0] r_q;
	logic [6:0] c_q;
	logic [7:0] top_q;
	logic [ROW_W-1:0] bot_q;
	logic [6:0] left_q;
	logic [6:0] right_q;
	logic [7:0] lines_q;
	logic [7:0] attr_q;
	logic up_q;

	// write stage of the scroll pipeline
	logic we_s1;
	tws_pkg::addr_t waddr_s1;
	logic blank_s1;
	logic srcok_s1;

	logic rdok_q;
	logic [7:0] res_char_q;
	logic [7:0] res_attr_q;
	logic res_done_q;
	logic out_valid_q;
	logic [7:0] out_char_q;
	logic [7:0] out_attr_q;
	logic out_done_q;

	logic ram_we;
	tws_pkg::addr_t ram_waddr;
	tws_pkg::cell_t ram_wdata;
	logic ram_re;
	tws_pkg::addr_t ram_raddr;
	tws_pkg::cell_t ram_rdata;

	logic accept;
	logic [OFF_W-1:0] c_off;
	logic cell_ok;
	tws_pkg::addr_t cell_addr;
	logic [7:0] bot_c;
	logic [7:0] right_c;
	logic win_empty;
	logic is_scroll;
	logic [8:0] up_sum;
	logic [8:0] dn_lim;
	logic copy;
	logic [ROW_W-1:0] src_row;
	logic [OFF_W-1:0] src_off;
	logic [OFF_W-1:0] dst_off;
	tws_pkg::addr_t page_base;
	logic last_col;
	logic last_row;
	logic out_free;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign is_scroll = (operation == tws_pkg::OP_SCR_UP) || (operation == tws_pkg::OP_SCR_DN);

	// cell address for write and read
	assign c_off = OFF_W'(row) * OFF_W'(cols_q) + OFF_W'(col);
	assign cell_ok = (int'(page) < tws_pkg::PAGES) && (int'(row) < tws_pkg::ROWS)
		&& (col < cols_q) && (int'(c_off) < tws_pkg::CELLS_PER_PAGE);
	assign cell_addr = ADDR_W'(page) * ADDR_W'(tws_pkg::CELLS_PER_PAGE) + ADDR_W'(c_off);

	// window clipping
	assign bot_c = (int'(bottom) > tws_pkg::ROWS - 1) ? 8'(tws_pkg::ROWS - 1) : bottom;
	assign right_c = (right > {1'b0, cols_q - 7'd1}) ? {1'b0, cols_q - 7'd1} : right;
	assign win_empty = (cols_q == 7'd0) || (top > bot_c) || (left > right_c);

	// source row selection for the scan
	assign up_sum = {{(9 - ROW_W){1'b0}}, r_q} + {1'b0, lines_q};
	assign dn_lim = {1'b0, top_q} + {1'b0, lines_q};
	assign copy = up_q ? (up_sum <= {{(9 - ROW_W){1'b0}}, bot_q})
		: ({{(9 - ROW_W){1'b0}}, r_q} >= dn_lim);
	always_comb begin
		logic [8:0] diff;
		diff = {{(9 - ROW_W){1'b0}}, r_q} - {1'b0, lines_q};
		src_row = up_q ? up_sum[ROW_W-1:0] : diff[ROW_W-1:0];
	end
	assign src_off = OFF_W'(src_row) * OFF_W'(cols_q) + OFF_W'(c_q);
	assign dst_off = OFF_W'(r_q) * OFF_W'(cols_q) + OFF_W'(c_q);
	assign page_base = ADDR_W'(apage_q) * ADDR_W'(tws_pkg::CELLS_PER_PAGE);
	assign last_col = (c_q == right_q);
	assign last_row = up_q ? (r_q == bot_q) : ({{(8 - ROW_W){1'b0}}, r_q} == top_q);

	// memory port steering
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = '0;
		if (we_s1) begin
			ram_we = 1'b1;
			ram_waddr = waddr_s1;
			ram_wdata = blank_s1 ? {attr_q, tws_pkg::BLANK_CHAR}
				: (srcok_s1 ? ram_rdata : '0);
		end else if (state_q == ST_INIT) begin
			ram_we = 1'b1;
			ram_waddr = cnt_q;
		end else if (state_q == ST_CLR) begin
			ram_we = 1'b1;
			ram_waddr = page_base + cnt_q;
		end else if (accept && operation == tws_pkg::OP_WRITE && cell_ok) begin
			ram_we = 1'b1;
			ram_waddr = cell_addr;
			ram_wdata = {attribute, char_code};
		end
		if (accept && operation == tws_pkg::OP_READ) begin
			ram_re = cell_ok;
			ram_raddr = cell_addr;
		end else if (state_q == ST_SCAN && copy
				&& int'(src_off) < tws_pkg::CELLS_PER_PAGE) begin
			ram_re = 1'b1;
			ram_raddr = page_base + ADDR_W'(src_off);
		end
	end

	tws_ram #(
		.DEPTH(tws_pkg::STORE_DEPTH),
		.WIDTH(tws_pkg::CELL_W)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= tws_pkg::COLS_RESET;
			apage_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tws_pkg::CFG_COLS: cols_q <= cfg_data;
				tws_pkg::CFG_APAGE: apage_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// scroll write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
		end else begin
			we_s1 <= (state_q == ST_SCAN) && (int'(dst_off) < tws_pkg::CELLS_PER_PAGE);
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= page_base + ADDR_W'(dst_off);
		blank_s1 <= !copy;
		srcok_s1 <= int'(src_off) < tws_pkg::CELLS_PER_PAGE;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(tws_pkg::STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (operation == tws_pkg::OP_READ) begin
							state_q <= ST_RD;
						end else if ((operation == tws_pkg::OP_CLEAR
								|| (is_scroll && lines == 8'd0))
								&& int'(apage_q) < tws_pkg::PAGES) begin
							state_q <= ST_CLR;
						end else if (is_scroll && lines != 8'd0 && !win_empty
								&& int'(apage_q) < tws_pkg::PAGES) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_RD: state_q <= ST_FIN;
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(tws_pkg::CELLS_PER_PAGE - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_SCAN: begin
					if (last_col && last_row) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// window walk and captured item fields
	always_ff @(posedge clk) begin
		if (accept) begin
			up_q <= (operation == tws_pkg::OP_SCR_UP);
			top_q <= top;
			bot_q <= bot_c[ROW_W-1:0];
			left_q <= left[6:0];
			right_q <= right_c[6:0];
			lines_q <= lines;
			attr_q <= attribute;
			c_q <= left[6:0];
			r_q <= (operation == tws_pkg::OP_SCR_UP) ? top[ROW_W-1:0] : bot_c[ROW_W-1:0];
			rdok_q <= cell_ok;
			res_char_q <= '0;
			res_attr_q <= '0;
			res_done_q <= (int'(operation) <= int'(tws_pkg::OP_CLEAR));
		end else if (state_q == ST_SCAN) begin
			if (last_col) begin
				c_q <= left_q;
				r_q <= up_q ? r_q + 1'b1 : r_q - 1'b1;
			end else begin
				c_q <= c_q + 1'b1;
			end
		end else if (state_q == ST_RD && rdok_q) begin
			res_char_q <= ram_rdata[7:0];
			res_attr_q <= ram_rdata[15:8];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_char_q <= res_char_q;
			out_attr_q <= res_attr_q;
			out_done_q <= res_done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_char = out_char_q;
	assign read_attribute = out_attr_q;
	assign done_res = out_done_q;

`ifndef NO_ASSERTIONS
	// a new result beat only comes out of the finish state
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result beat without finished operation");

	// memory writes stay inside the store
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (int'(ram_waddr) < tws_pkg::STORE_DEPTH))
		else $error("memory write beyond store");

	// the column walk never leaves the window
	a_col_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (c_q >= left_q && c_q <= right_q))
		else $error("scroll column outside window");

	// a scroll read never targets the entry written in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(we_s1 && ram_re) |-> (ram_raddr != ram_waddr))
		else $error("read and write of the same cell in one cycle");
`endif

endmodule

>>> sv/tws_ram.sv
// tws_ram: single write port, single read port cell memory, registered read
// no dependencies
module tws_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for text_window_scroll, cell ops, scrolls and page clears
// depends on tws_pkg and the text_window_scroll rtl
module tb_top;

	typedef struct packed {
		logic [2:0] operation;
		logic [2:0] page;
		logic [4:0] row;
		logic [6:0] col;
		logic [7:0] char_code;
		logic [7:0] attribute;
		logic [7:0] lines;
		logic [7:0] top;
		logic [7:0] left;
		logic [7:0] bottom;
		logic [7:0] right;
	} cmd_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] attr;
		logic       done;
	} resp_t;

	localparam longint CYCLE_LIMIT = 64'd40_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	cmd_t drv = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] read_char;
	logic [7:0] read_attribute;
	logic done_res;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = 1'b0;
	logic [6:0] cfg_data = '0;

	// model state
	tws_pkg::cell_t screen_mem [tws_pkg::STORE_DEPTH];
	int unsigned mdl_cols;
	int unsigned mdl_apage;

	cmd_t cmd_q[$];
	resp_t resp_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	longint cycles = 0;

	text_window_scroll DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(drv.operation), .page(drv.page), .row(drv.row), .col(drv.col),
		.char_code(drv.char_code), .attribute(drv.attribute), .lines(drv.lines),
		.top(drv.top), .left(drv.left), .bottom(drv.bottom), .right(drv.right),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_char(read_char), .read_attribute(read_attribute), .done_res(done_res),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// cell address lookup, -1 when the cell does not exist
	function automatic int cell_addr(int unsigned pg, int unsigned r, int unsigned c);
		int unsigned off;
		if (pg >= tws_pkg::PAGES || r >= tws_pkg::ROWS || c >= mdl_cols)
			return -1;
		off = r * mdl_cols + c;
		if (off >= tws_pkg::CELLS_PER_PAGE)
			return -1;
		return pg * tws_pkg::CELLS_PER_PAGE + off;
	endfunction

	function automatic tws_pkg::cell_t cell_rd(int unsigned pg, int unsigned r,
	                                           int unsigned c);
		int a;
		a = cell_addr(pg, r, c);
		return (a < 0) ? tws_pkg::cell_t'(0) : screen_mem[a];
	endfunction

	function automatic void cell_wr(int unsigned pg, int unsigned r, int unsigned c,
	                                tws_pkg::cell_t v);
		int a;
		a = cell_addr(pg, r, c);
		if (a >= 0)
			screen_mem[a] = v;
	endfunction

	function automatic void page_wipe(int unsigned pg);
		for (int i = 0; i < tws_pkg::CELLS_PER_PAGE; i++)
			screen_mem[pg * tws_pkg::CELLS_PER_PAGE + i] = '0;
	endfunction

	// window scroll on the active page
	function automatic void window_scroll(logic up, cmd_t c);
		int unsigned bot, rgt, r;
		tws_pkg::cell_t blank;
		blank = {c.attribute, tws_pkg::BLANK_CHAR};
		if (mdl_apage >= tws_pkg::PAGES)
			return;
		if (c.lines == 0) begin
			page_wipe(mdl_apage);
			return;
		end
		if (mdl_cols == 0)
			return;
		bot = (c.bottom > tws_pkg::ROWS - 1) ? tws_pkg::ROWS - 1 : c.bottom;
		rgt = (c.right > mdl_cols - 1) ? mdl_cols - 1 : c.right;
		if (c.top > bot || c.left > rgt)
			return;
		for (int unsigned k = 0; k <= bot - c.top; k++) begin
			r = up ? c.top + k : bot - k;
			for (int unsigned cc = c.left; cc <= rgt; cc++) begin
				if (up)
					cell_wr(mdl_apage, r, cc, (r + c.lines <= bot) ?
						cell_rd(mdl_apage, r + c.lines, cc) : blank);
				else
					cell_wr(mdl_apage, r, cc, (r >= c.top + c.lines) ?
						cell_rd(mdl_apage, r - c.lines, cc) : blank);
			end
		end
	endfunction

	function automatic resp_t screen_op(cmd_t c);
		resp_t rs;
		tws_pkg::cell_t v;
		rs = '0;
		case (c.operation)
			tws_pkg::OP_WRITE: begin
				cell_wr(c.page, c.row, c.col, {c.attribute, c.char_code});
				rs.done = 1'b1;
			end
			tws_pkg::OP_READ: begin
				v = cell_rd(c.page, c.row, c.col);
				rs.ch = v[7:0];
				rs.attr = v[15:8];
				rs.done = 1'b1;
			end
			tws_pkg::OP_SCR_UP, tws_pkg::OP_SCR_DN: begin
				window_scroll(c.operation == tws_pkg::OP_SCR_UP, c);
				rs.done = 1'b1;
			end
			tws_pkg::OP_CLEAR: begin
				if (mdl_apage < tws_pkg::PAGES)
					page_wipe(mdl_apage);
				rs.done = 1'b1;
			end
			default: ;
		endcase
		return rs;
	endfunction

	// driver: offer queued beats, random sender idling
	always @(posedge clk) begin
		if (!in_valid || !in_stall) begin
			if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				drv <= cmd_q[0];
				resp_q.push_back(screen_op(cmd_q.pop_front()));
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with a long hold-off when requested
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		resp_t exp_r;
		if (out_valid && !out_stall) begin
			if (resp_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: %h %h %b",
						read_char, read_attribute, done_res);
			end else begin
				exp_r = resp_q.pop_front();
				if (exp_r.ch !== read_char || exp_r.attr !== read_attribute ||
				    exp_r.done !== done_res) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %h %h %b got %h %h %b",
							exp_r.ch, exp_r.attr, exp_r.done,
							read_char, read_attribute, done_res);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("text_window_scroll regression: fail");
			$finish;
		end
	end

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int sel;
		c = '0;
		sel = $urandom_range(99);
		c.operation = (sel < 40) ? tws_pkg::OP_WRITE : (sel < 75) ? tws_pkg::OP_READ :
			(sel < 85) ? tws_pkg::OP_SCR_UP : (sel < 95) ? tws_pkg::OP_SCR_DN :
			(sel < 97) ? tws_pkg::OP_CLEAR : 3'($urandom_range(7, 5));
		c.page = 3'(($urandom_range(3) == 0) ? $urandom_range(7) : mdl_apage);
		c.row = 5'(($urandom_range(9) == 0) ? $urandom_range(31)
			: $urandom_range(tws_pkg::ROWS - 1));
		c.col = 7'(($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(79));
		c.char_code = 8'($urandom_range(255));
		c.attribute = 8'($urandom_range(255));
		c.lines = ($urandom_range(19) == 0) ? 8'd0 :
			8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 8));
		c.top = 8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(24));
		c.bottom = 8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(24));
		c.left = 8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(79));
		c.right = 8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(79));
		// keep windows mostly well ordered
		if ($urandom_range(4) != 0) begin
			if (c.top > c.bottom) {c.top, c.bottom} = {c.bottom, c.top};
			if (c.left > c.right) {c.left, c.right} = {c.right, c.left};
		end
		return c;
	endfunction

	function automatic cmd_t mk(logic [2:0] op, int pg, int r, int cl, int ch, int at,
	                            int ln, int t, int l, int b, int rt);
		cmd_t c;
		c.operation = op;
		c.page = 3'(pg);
		c.row = 5'(r);
		c.col = 7'(cl);
		c.char_code = 8'(ch);
		c.attribute = 8'(at);
		c.lines = 8'(ln);
		c.top = 8'(t);
		c.left = 8'(l);
		c.bottom = 8'(b);
		c.right = 8'(rt);
		return c;
	endfunction

	// wait for drain, then let any trailing work finish
	task automatic drain();
		while (cmd_q.size() > 0 || resp_q.size() > 0 || in_valid)
			@(posedge clk);
		repeat (4200) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, int unsigned val);
		cfg_index <= idx;
		cfg_data <= val[6:0];
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == tws_pkg::CFG_COLS)
			mdl_cols = val & 7'h7f;
		else
			mdl_apage = val & 3'h7;
		@(posedge clk);
	endtask

	task automatic run_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) cmd_q.push_back(rand_cmd());
		drain();
	endtask

	initial begin
		for (int i = 0; i < tws_pkg::STORE_DEPTH; i++)
			screen_mem[i] = '0;
		mdl_cols = tws_pkg::COLS_RESET;
		mdl_apage = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and every operation
		cmd_q.push_back(mk(tws_pkg::OP_WRITE, 0, 0, 0, 8'hff, 8'hff, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_WRITE, 7, 24, 79, 8'h00, 8'h80, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_WRITE, 0, 1, 0, 8'h41, 8'h07, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_WRITE, 0, 31, 127, 8'h55, 8'haa, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_READ, 7, 24, 79, 0, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_READ, 0, 31, 127, 0, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_SCR_UP, 0, 0, 0, 0, 8'h17, 1, 0, 0, 255, 255));
		cmd_q.push_back(mk(tws_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_SCR_DN, 0, 0, 0, 0, 8'h71, 2, 0, 0, 24, 79));
		cmd_q.push_back(mk(tws_pkg::OP_READ, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_SCR_UP, 0, 0, 0, 0, 8'h1f, 255, 3, 5, 6, 9));
		cmd_q.push_back(mk(tws_pkg::OP_SCR_DN, 0, 0, 0, 0, 8'h1f, 1, 9, 0, 3, 79));
		cmd_q.push_back(mk(tws_pkg::OP_SCR_UP, 0, 0, 0, 0, 8'h1f, 1, 0, 50, 24, 10));
		cmd_q.push_back(mk(tws_pkg::OP_READ, 0, 4, 6, 0, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_SCR_UP, 0, 0, 0, 0, 8'hff, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_READ, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(tws_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(3'd5, 7, 31, 127, 255, 255, 255, 255, 255, 255, 255));
		cmd_q.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		drain();

		run_random(60, 0, 0);
		cfg_write(tws_pkg::CFG_COLS, 40);
		cfg_write(tws_pkg::CFG_APAGE, 7);
		run_random(60, 66, 0);
		cfg_write(tws_pkg::CFG_COLS, 127);
		cfg_write(tws_pkg::CFG_APAGE, 3);
		// long receiver hold-off while the sender keeps offering
		hold_cycles = 3000;
		run_random(60, 0, 66);
		cfg_write(tws_pkg::CFG_COLS, 0);
		run_random(20, 30, 30);
		cfg_write(tws_pkg::CFG_COLS, 80);
		cfg_write(tws_pkg::CFG_APAGE, 0);
		run_random(60, 30, 30);
		cfg_write(tws_pkg::CFG_COLS, 1);
		cfg_write(tws_pkg::CFG_APAGE, 5);
		run_random(20, 0, 0);
		cfg_write(tws_pkg::CFG_COLS, 80);
		cfg_write(tws_pkg::CFG_APAGE, 1);
		run_random(30, 0, 0);

		if (errors == 0)
			$display("text_window_scroll regression: pass");
		else
			$display("text_window_scroll regression: fail");
		$finish;
	end
endmodule

>>> sim.f
sv/tws_pkg.sv
sv/tws_ram.sv
sv/text_window_scroll.sv
tb/tb_top.sv
